FILE: rtl/core/bfpu_pkg.sv
// Package for the bit field pack/unpack store unit.
// Holds field widths, request and command codes, the back-end state type
// and the command record that travels from the front end to the back end.
package bfpu_pkg;

    localparam int STORE_WORDS_DEF = 64;
    localparam int WORD_W          = 64;
    localparam int OFF_W           = 6;
    localparam int CNT_W           = 7;
    localparam int BYTE_W          = 10;
    localparam int POS_OUT_W       = 13;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_SEEK  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_type_t;

    // Work left for the back end once the front end has classified a request.
    typedef enum logic [1:0] {
        OP_PASS  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        BK_SWEEP    = 2'd0,
        BK_IDLE     = 2'd1,
        BK_ACCESS   = 2'd2,
        BK_WRITE_HI = 2'd3
    } bk_state_t;

    typedef struct packed {
        op_t                    op;
        logic [OFF_W-1:0]       offset;
        logic [CNT_W-1:0]       width;
        logic                   span;
        logic [WORD_W-1:0]      value;
        logic                   overflow;
        logic [POS_OUT_W-1:0]   pos_after;
    } cmd_t;

endpackage

FILE: rtl/core/bfpu_if.sv
// Handshake interfaces for the request and response channels.
// Depends on bfpu_pkg for the field widths.
interface bfpu_req_if
    import bfpu_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [1:0]          req_type;
    logic [CNT_W-1:0]    bit_count;
    logic [WORD_W-1:0]   write_value;
    logic [BYTE_W-1:0]   byte_position;

    modport source (output valid, req_type, bit_count, write_value, byte_position,
                    input ready);
    modport sink   (input valid, req_type, bit_count, write_value, byte_position,
                    output ready);
    modport mon    (input valid, ready, req_type, bit_count, write_value,
                    byte_position);
endinterface

interface bfpu_rsp_if
    import bfpu_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [WORD_W-1:0]     read_data;
    logic                  overflow;
    logic [POS_OUT_W-1:0]  bit_position_after;

    modport source (output valid, read_data, overflow, bit_position_after,
                    input ready);
    modport sink   (input valid, read_data, overflow, bit_position_after,
                    output ready);
    modport mon    (input valid, ready, read_data, overflow, bit_position_after);
endinterface

FILE: rtl/core/bfpu_front.sv
// Front end: accepts request transactions, keeps the bit position and
// classifies each request into a command for the back end. Uses bfpu_pkg.
module bfpu_front
    import bfpu_pkg::*;
#(
    parameter int STORE_WORDS = STORE_WORDS_DEF,
    localparam int AW = $clog2(STORE_WORDS)
) (
    input  logic            clk,
    input  logic            rst_n,
    bfpu_req_if.sink        req,
    input  logic            store_ready,
    input  logic            q_full,
    output logic            push,
    output cmd_t            push_cmd,
    output logic [AW-1:0]   push_idx
);

    localparam int CAP = STORE_WORDS * WORD_W;
    localparam int PW  = $clog2(CAP + 1);
    localparam int CW  = (PW > POS_OUT_W) ? PW : POS_OUT_W;

    logic [PW-1:0]    pos_reg;
    logic [PW-1:0]    pos_next;
    logic [CNT_W-1:0] n_sat;
    logic [PW:0]      pos_sum;
    logic             ovf;
    logic [CW-1:0]    seek_ext;
    logic [OFF_W-1:0] off;

    assign req.ready = store_ready && !q_full;
    assign push      = req.valid && req.ready;

    assign n_sat    = (req.bit_count > CNT_W'(WORD_W)) ? CNT_W'(WORD_W) : req.bit_count;
    assign pos_sum  = {1'b0, pos_reg} + (PW + 1)'(n_sat);
    assign ovf      = pos_sum > (PW + 1)'(CAP);
    assign seek_ext = CW'({req.byte_position, 3'b000});
    assign off      = pos_reg[OFF_W-1:0];
    assign push_idx = pos_reg[AW+OFF_W-1:OFF_W];

    always_comb
    begin
        pos_next        = pos_reg;
        push_cmd.op     = OP_PASS;
        push_cmd.offset = off;
        push_cmd.width  = n_sat;
        // The field runs into the next word when it crosses a word boundary.
        push_cmd.span   = (CNT_W'(off) + n_sat) > CNT_W'(WORD_W);
        push_cmd.value  = req.write_value;
        push_cmd.overflow = 1'b0;
        unique case (req_type_t'(req.req_type)) inside
            REQ_READ, REQ_WRITE:
            begin
                if (n_sat != '0)
                begin
                    if (ovf)
                    begin
                        push_cmd.overflow = 1'b1;
                    end
                    else
                    begin
                        push_cmd.op = (req_type_t'(req.req_type) == REQ_READ) ?
                                      OP_READ : OP_WRITE;
                        pos_next    = pos_sum[PW-1:0];
                    end
                end
            end
            REQ_SEEK:
            begin
                pos_next = (seek_ext > CW'(CAP)) ? PW'(CAP) : seek_ext[PW-1:0];
            end
            REQ_CLEAR:
            begin
                push_cmd.op = OP_CLEAR;
                pos_next    = '0;
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
        push_cmd.pos_after = POS_OUT_W'(pos_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (push)
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

FILE: rtl/core/bfpu_queue.sv
// Short command queue between the front end and the back end.
// Uses cmd_t and QUEUE_DEPTH from bfpu_pkg.
module bfpu_queue
    import bfpu_pkg::*;
#(
    parameter int IDX_W = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cmd_t              push_cmd,
    input  logic [IDX_W-1:0]  push_idx,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output cmd_t              head_cmd,
    output logic [IDX_W-1:0]  head_idx
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    cmd_t              cmd_mem [QUEUE_DEPTH];
    logic [IDX_W-1:0]  idx_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_QW-1:0] count_reg;
    logic [CNT_QW-1:0] count_next;

    assign full       = count_reg == CNT_QW'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = cmd_mem[rd_ptr_reg];
    assign head_idx   = idx_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_mem[wr_ptr_reg] <= push_cmd;
            idx_mem[wr_ptr_reg] <= push_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/bfpu_back.sv
// Back end: owns the word store, carries out field reads, field writes and
// clearing sweeps, and holds the response register. Uses bfpu_pkg.
module bfpu_back
    import bfpu_pkg::*;
#(
    parameter int STORE_WORDS = STORE_WORDS_DEF,
    localparam int AW = $clog2(STORE_WORDS)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  cmd_t            q_cmd,
    input  logic [AW-1:0]   q_idx,
    output logic            pop,
    output logic            store_ready,
    bfpu_rsp_if.source      rsp
);

    logic [WORD_W-1:0] mem [STORE_WORDS];

    bk_state_t         state_reg;
    bk_state_t         state_next;
    logic [AW-1:0]     sweep_cnt_reg;
    logic [AW-1:0]     sweep_cnt_next;
    cmd_t              cmd_reg;
    logic [AW-1:0]     idx_reg;
    logic [WORD_W-1:0] rd_lo_reg;
    logic [WORD_W-1:0] rd_hi_reg;

    logic                  out_valid_reg;
    logic [WORD_W-1:0]     out_data_reg;
    logic                  out_ovf_reg;
    logic [POS_OUT_W-1:0]  out_pos_reg;

    logic              out_free;
    logic              emit;
    cmd_t              emit_cmd;
    logic [WORD_W-1:0] emit_data;
    logic              mem_we;
    logic [AW-1:0]     waddr;
    logic [WORD_W-1:0] wdata;
    logic [AW-1:0]     raddr_hi;
    logic [AW-1:0]     idx_hi;

    logic [WORD_W-1:0] mask;
    logic [CNT_W-1:0]  sh_hi;
    logic [WORD_W-1:0] field;
    logic [WORD_W-1:0] wval;
    logic [WORD_W-1:0] lo_word;
    logic [WORD_W-1:0] hi_word;

    assign out_free    = !out_valid_reg || rsp.ready;
    assign store_ready = state_reg != BK_SWEEP;
    assign raddr_hi    = q_cmd.span ? q_idx + 1'b1 : q_idx;
    assign idx_hi      = idx_reg + 1'b1;

    // Field extract and merge on the two words read for the current command.
    assign mask    = (cmd_reg.width >= CNT_W'(WORD_W)) ? '1 :
                     (WORD_W'(1) << cmd_reg.width) - 1'b1;
    assign sh_hi   = CNT_W'(WORD_W) - CNT_W'(cmd_reg.offset);
    assign field   = ((rd_lo_reg >> cmd_reg.offset) |
                      (cmd_reg.span ? (rd_hi_reg << sh_hi) : '0)) & mask;
    assign wval    = cmd_reg.value & mask;
    assign lo_word = (rd_lo_reg & ~(mask << cmd_reg.offset)) | (wval << cmd_reg.offset);
    assign hi_word = (rd_hi_reg & ~(mask >> sh_hi)) | (wval >> sh_hi);

    always_comb
    begin
        state_next     = state_reg;
        sweep_cnt_next = sweep_cnt_reg;
        pop            = 1'b0;
        emit           = 1'b0;
        emit_cmd       = cmd_reg;
        emit_data      = '0;
        mem_we         = 1'b0;
        waddr          = idx_reg;
        wdata          = lo_word;
        unique case (state_reg)
            BK_SWEEP:
            begin
                mem_we = 1'b1;
                waddr  = sweep_cnt_reg;
                wdata  = '0;
                if (sweep_cnt_reg == AW'(STORE_WORDS - 1))
                begin
                    sweep_cnt_next = '0;
                    state_next     = BK_IDLE;
                end
                else
                begin
                    sweep_cnt_next = sweep_cnt_reg + 1'b1;
                end
            end
            BK_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    pop      = 1'b1;
                    emit_cmd = q_cmd;
                    case (q_cmd.op) inside
                        OP_READ, OP_WRITE:
                        begin
                            state_next = BK_ACCESS;
                        end
                        OP_CLEAR:
                        begin
                            emit           = 1'b1;
                            sweep_cnt_next = '0;
                            state_next     = BK_SWEEP;
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            BK_ACCESS:
            begin
                emit = 1'b1;
                if (cmd_reg.op == OP_READ)
                begin
                    emit_data  = field;
                    state_next = BK_IDLE;
                end
                else
                begin
                    mem_we     = 1'b1;
                    state_next = cmd_reg.span ? BK_WRITE_HI : BK_IDLE;
                end
            end
            BK_WRITE_HI:
            begin
                mem_we     = 1'b1;
                waddr      = idx_hi;
                wdata      = hi_word;
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Word store: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (pop)
        begin
            rd_lo_reg <= mem[q_idx];
            rd_hi_reg <= mem[raddr_hi];
            cmd_reg   <= q_cmd;
            idx_reg   <= q_idx;
        end
        if (emit)
        begin
            out_data_reg <= emit_data;
            out_ovf_reg  <= emit_cmd.overflow;
            out_pos_reg  <= emit_cmd.pos_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_SWEEP;
            sweep_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            out_valid_reg <= emit || (out_valid_reg && !rsp.ready);
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.read_data          = out_data_reg;
    assign rsp.overflow           = out_ovf_reg;
    assign rsp.bit_position_after = out_pos_reg;

endmodule

FILE: rtl/core/bit_field_pack_unpack_store_unit.sv
// Top level of the bit field pack/unpack store unit.
// Connects bfpu_front, bfpu_queue and bfpu_back; uses bfpu_pkg and bfpu_if.
//
// Usage: the req channel carries one request per transaction (read field,
// write field, seek to byte, clear store); the rsp channel returns exactly
// one response transaction per request, in order, with the right-aligned
// field for reads, the overflow flag and the bit position after the request.
// The front end updates the bit position at accept and queues a command; the
// back end works through the word store, which has one write port and two
// registered read ports.
// Seek, clear, zero-width and refused requests are answered from the idle
// state straight into the response register; reads and writes first load
// the two store words and are answered from the access state. In the back
// end, a write that spans two words adds a step for the upper word, and a
// clear then sweeps the store, one word zeroed per cycle, with req ready low
// during the sweep.
// After reset the same clearing pass runs with req ready low. When the
// receiver stalls, the response register holds; the queue of two commands
// keeps taking requests until it fills.
module bit_field_pack_unpack_store_unit
    import bfpu_pkg::*;
#(
    parameter int STORE_WORDS = STORE_WORDS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bfpu_req_if.sink   req,
    bfpu_rsp_if.source rsp
);

    localparam int AW = $clog2(STORE_WORDS);

    logic            store_ready;
    logic            q_full;
    logic            push;
    cmd_t            push_cmd;
    logic [AW-1:0]   push_idx;
    logic            pop;
    logic            head_valid;
    cmd_t            head_cmd;
    logic [AW-1:0]   head_idx;

    bfpu_front #(
        .STORE_WORDS (STORE_WORDS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .store_ready (store_ready),
        .q_full      (q_full),
        .push        (push),
        .push_cmd    (push_cmd),
        .push_idx    (push_idx)
    );

    bfpu_queue #(
        .IDX_W (AW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_idx   (push_idx),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .head_idx   (head_idx)
    );

    bfpu_back #(
        .STORE_WORDS (STORE_WORDS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (head_valid),
        .q_cmd       (head_cmd),
        .q_idx       (head_idx),
        .pop         (pop),
        .store_ready (store_ready),
        .rsp         (rsp)
    );

endmodule

FILE: rtl/core/bfpu_checker.sv
// Port-level checker for the bit field pack/unpack store unit, with its bind.
// Depends on bfpu_pkg and the bfpu_req_if / bfpu_rsp_if interfaces.
module bfpu_checker
    import bfpu_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic [WORD_W-1:0]     rsp_read_data,
    input logic                  rsp_overflow,
    input logic [POS_OUT_W-1:0]  rsp_bit_position_after
);

    localparam int MAX_OUT = QUEUE_DEPTH + 2;
    localparam int OW = $clog2(MAX_OUT + 2);

    logic          req_acc;
    logic          rsp_acc;
    logic [OW-1:0] outstanding_reg;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else if (req_acc && !rsp_acc)
        begin
            outstanding_reg <= outstanding_reg + 1'b1;
        end
        else if (rsp_acc && !req_acc)
        begin
            outstanding_reg <= outstanding_reg - 1'b1;
        end
    end

    // Every response transaction answers a request taken earlier.
    a_rsp_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> outstanding_reg != '0)
        else $error("response without an outstanding request");

    // Queue, back end and response register bound the requests in flight.
    a_bounded_flight: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= OW'(MAX_OUT))
        else $error("too many requests in flight");

    // A refused field never carries data.
    a_ovf_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_overflow) |-> rsp_read_data == '0)
        else $error("overflow response with nonzero data");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_read_data) && $stable(rsp_overflow) &&
             $stable(rsp_bit_position_after)))
        else $error("stalled response changed");

endmodule

bind bit_field_pack_unpack_store_unit bfpu_checker u_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .req_valid              (req.valid),
    .req_ready              (req.ready),
    .rsp_valid              (rsp.valid),
    .rsp_ready              (rsp.ready),
    .rsp_read_data          (rsp.read_data),
    .rsp_overflow           (rsp.overflow),
    .rsp_bit_position_after (rsp.bit_position_after)
);
